@@ sv/sli_pkg.sv @@
package sli_pkg;

    localparam int VALUE_W = 32;
    localparam int ENTRY_W = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [VALUE_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic                       ok;
        logic [ENTRY_W-1:0]         entry_count;
        logic signed [VALUE_W-1:0]  smallest;
        logic                       smallest_valid;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_HEAD,
        ST_REM,
        ST_DONE
    } state_t;

    // signed order compare on raw bit patterns
    function automatic logic key_ge(input logic [VALUE_W-1:0] a,
                                    input logic [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] ka;
        logic [VALUE_W-1:0] kb;
        ka = {~a[VALUE_W-1], a[VALUE_W-2:0]};
        kb = {~b[VALUE_W-1], b[VALUE_W-2:0]};
        return ka >= kb;
    endfunction

endpackage

@@ sv/sli_mem.sv @@
module sli_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic [sli_pkg::VALUE_W-1:0]       wdata,
    input  logic [AW-1:0]                     raddr,
    output logic [sli_pkg::VALUE_W-1:0]       rdata
);

    logic [sli_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [sli_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/sli_seq.sv @@
module sli_seq #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  sli_pkg::in_item_t                 item,
    input  logic                              res_free,
    output logic                              idle,
    output logic                              res_valid,
    output sli_pkg::out_item_t                res,
    output logic                              mem_we,
    output logic [AW-1:0]                     mem_waddr,
    output logic [sli_pkg::VALUE_W-1:0]       mem_wdata,
    output logic [AW-1:0]                     mem_raddr,
    input  logic [sli_pkg::VALUE_W-1:0]       mem_rdata
);

    sli_pkg::state_t                 state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic [sli_pkg::VALUE_W-1:0]     val_reg, val_next;
    logic [sli_pkg::VALUE_W-1:0]     smallest_reg, smallest_next;
    logic                            found_reg, found_next;
    logic                            ok_reg, ok_next;

    logic                            is_full;
    logic                            is_empty;
    logic                            rd_ge;
    logic                            hit;
    logic                            last;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign rd_ge    = sli_pkg::key_ge(mem_rdata, val_reg);
    assign hit      = !found_reg && (mem_rdata == val_reg);
    assign last     = ((CW'(idx_reg) + 1'b1) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sli_pkg::ST_IDLE;
            count_reg <= '0;
            found_reg <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            found_reg <= found_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        smallest_reg <= smallest_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sli_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (item.action == sli_pkg::ACT_INSERT)
                    begin
                        state_next = (is_full || is_empty) ? sli_pkg::ST_DONE
                                                           : sli_pkg::ST_INS;
                    end
                    else
                    begin
                        state_next = is_empty ? sli_pkg::ST_DONE : sli_pkg::ST_REM;
                    end
                end
            end
            sli_pkg::ST_INS:
            begin
                if (!rd_ge)
                begin
                    state_next = sli_pkg::ST_DONE;
                end
                else if (idx_reg == '0)
                begin
                    state_next = sli_pkg::ST_INS_HEAD;
                end
            end
            sli_pkg::ST_INS_HEAD:
            begin
                state_next = sli_pkg::ST_DONE;
            end
            sli_pkg::ST_REM:
            begin
                if (last)
                begin
                    state_next = sli_pkg::ST_DONE;
                end
            end
            sli_pkg::ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = sli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sli_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        smallest_next = smallest_reg;
        found_next    = found_reg;
        ok_next       = ok_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = val_reg;
        mem_raddr     = idx_reg;
        res_valid     = 1'b0;
        unique case (state_reg)
            sli_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    val_next   = item.value;
                    found_next = 1'b0;
                    if (item.action == sli_pkg::ACT_INSERT)
                    begin
                        if (is_full)
                        begin
                            ok_next = 1'b0;
                        end
                        else if (is_empty)
                        begin
                            // first entry goes straight to the head
                            mem_we        = 1'b1;
                            mem_waddr     = '0;
                            mem_wdata     = item.value;
                            count_next    = CW'(1);
                            smallest_next = item.value;
                            ok_next       = 1'b1;
                        end
                        else
                        begin
                            // walk down from the tail
                            idx_next  = AW'(count_reg - 1'b1);
                            mem_raddr = AW'(count_reg - 1'b1);
                        end
                    end
                    else
                    begin
                        if (is_empty)
                        begin
                            ok_next = 1'b0;
                        end
                        else
                        begin
                            idx_next  = '0;
                            mem_raddr = '0;
                        end
                    end
                end
            end
            sli_pkg::ST_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + 1'b1;
                if (rd_ge)
                begin
                    // entry moves up one slot
                    mem_wdata = mem_rdata;
                    idx_next  = idx_reg - 1'b1;
                    mem_raddr = idx_reg - 1'b1;
                end
                else
                begin
                    mem_wdata  = val_reg;
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                    if (!sli_pkg::key_ge(val_reg, smallest_reg))
                    begin
                        smallest_next = val_reg;
                    end
                end
            end
            sli_pkg::ST_INS_HEAD:
            begin
                mem_we        = 1'b1;
                mem_waddr     = '0;
                mem_wdata     = val_reg;
                count_next    = count_reg + 1'b1;
                ok_next       = 1'b1;
                smallest_next = val_reg;
            end
            sli_pkg::ST_REM:
            begin
                found_next = found_reg || hit;
                if (found_reg)
                begin
                    // close the gap behind the removed entry
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg - 1'b1;
                    mem_wdata = mem_rdata;
                    if (idx_reg == AW'(1))
                    begin
                        smallest_next = mem_rdata;
                    end
                end
                if (last)
                begin
                    ok_next = found_reg || hit;
                    if (found_reg || hit)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    mem_raddr = idx_reg + 1'b1;
                end
            end
            sli_pkg::ST_DONE:
            begin
                res_valid = res_free;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign idle               = (state_reg == sli_pkg::ST_IDLE);
    assign res.ok             = ok_reg;
    assign res.entry_count    = sli_pkg::ENTRY_W'(count_reg);
    assign res.smallest       = is_empty ? '0 : smallest_reg;
    assign res.smallest_valid = !is_empty;

endmodule

@@ sv/sorted_list_insert_remove.sv @@
// sorted store of up to DEPTH signed 32-bit values in ascending order, duplicates
// allowed, kept in one single-port-write, registered-read memory. each input
// transaction either inserts a value at its sorted place or removes one occurrence
// of it, and produces exactly one result transaction: success, the entry count
// afterwards (modulo 32) and the smallest stored value with a valid flag (smallest
// reads zero when empty). one operation is handled at a time and the memory is
// walked one entry per cycle: an insert reads from the tail down to the insertion
// point, and an insert at the head finishes by writing the head slot; a remove
// scans from the head to the tail; a failed insert into a full store, an insert
// into an empty store and a remove from an empty store go straight to the
// result. the memory needs no clearing after reset
// since only the first count entries are ever read. the result sits in an output
// register, so the next transaction is taken while the previous result still waits
module sorted_list_insert_remove #(
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sli_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sli_pkg::out_item_t    out_data
);

    // address covers the entries, count must also hold DEPTH itself
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                            seq_idle;
    logic                            start;
    logic                            res_free;
    logic                            res_valid;
    sli_pkg::out_item_t              res;

    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [sli_pkg::VALUE_W-1:0]     mem_wdata;
    logic [AW-1:0]                   mem_raddr;
    logic [sli_pkg::VALUE_W-1:0]     mem_rdata;

    logic                            out_valid_reg, out_valid_next;
    sli_pkg::out_item_t              out_data_reg, out_data_next;

    // accept only while the sequencer is idle
    assign in_ready = seq_idle;
    assign start    = in_valid && seq_idle;

    // output slot is free when empty or being drained this cycle
    assign res_free = !out_valid_reg || out_ready;

    sli_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (in_data),
        .res_free  (res_free),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // the walk always writes a different slot from the one it reads,
    // so read and write in the same cycle never collide
    sli_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
